// ----- sv/ordered_value_list_macros.svh -----
// Assertion macros for the ordered value list RTL.
// Used by the datapath; no other dependencies.
`ifndef ORDERED_VALUE_LIST_MACROS_SVH
`define ORDERED_VALUE_LIST_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define OVL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define OVL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/ovl_pkg.sv -----
// Shared constants, codes and controller/datapath structs for the ordered value list.
// No dependencies.
package ovl_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND   = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_CONTAINS = 2'd2,
    CMD_READ     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RD_ZERO  = 2'd0,
    RD_POS   = 2'd1,
    RD_NEXT  = 2'd2,
    RD_NEXT2 = 2'd3
  } rd_sel_e;

  typedef enum logic [1:0] {
    IDX_HOLD = 2'd0,
    IDX_CLR  = 2'd1,
    IDX_INC  = 2'd2
  } idx_op_e;

  typedef struct packed {
    logic    latch;
    logic    do_append;
    logic    rd_en;
    rd_sel_e rd_sel;
    idx_op_e idx_op;
    logic    shift_wr;
    logic    cnt_dec;
    logic    res_load;
    logic    res_found;
    logic    res_drop;
    logic    res_use_rd;
    logic    out_load;
  } ctl_t;

  typedef struct packed {
    cmd_e cmd;
    logic full;
    logic empty;
    logic pos_ok;
    logic match;
    logic next_ok;
    logic next2_ok;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/ovl_intf.sv -----
// Valid/ready channel interfaces for list commands and list results.
// Depends on ovl_pkg.
interface ovl_in_if import ovl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;

  modport source (output valid, command, value, position, input ready);
  modport sink (input valid, command, value, position, output ready);
endinterface

interface ovl_out_if import ovl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic signed [VALUE_W-1:0] read_value;
  logic [COUNT_W-1:0]        count;
  logic                      full_drop;

  modport source (output valid, found, read_value, count, full_drop, input ready);
  modport sink (input valid, found, read_value, count, full_drop, output ready);
endinterface

// ----- sv/ordered_value_list.sv -----
// Ordered value list top: append, remove-first, contains and read-at-position.
// Each command passes ST_EXEC and then ST_DONE; an in-range read also passes ST_RDWAIT, and
// contains/remove on a non-empty list scan entries in ST_SCAN; a remove then shifts later entries in ST_SHIFT.
// One item in flight: a new command is accepted only after the last result is loaded for output.
// Reset (async, active low) empties the list; memory contents are not cleared.
module ordered_value_list import ovl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ovl_in_if.sink    in_i,
  ovl_out_if.source out_o
);

  ctl_t ctl;
  sts_t sts;

  ovl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  ovl_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .command_i  (in_i.command),
    .value_i    (in_i.value),
    .position_i (in_i.position),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .out_o      (out_o)
  );

endmodule

// ----- sv/ovl_ctrl.sv -----
// Controller FSM: sequences append, scan, shift and read over the list memory.
// Depends on ovl_pkg; drives the datapath through ctl_t, watches sts_t.
module ovl_ctrl import ovl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_SHIFT  = 3'd3;
  localparam logic [2:0] ST_RDWAIT = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '{rd_sel: RD_ZERO, idx_op: IDX_HOLD, default: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts_i.cmd)
          CMD_APPEND: begin
            ctl_o.res_load = 1'b1;
            if (sts_i.full) begin
              ctl_o.res_drop = 1'b1;
            end else begin
              ctl_o.do_append = 1'b1;
              ctl_o.res_found = 1'b1;
            end
            state_d = ST_DONE;
          end
          CMD_READ: begin
            if (sts_i.pos_ok) begin
              ctl_o.rd_en  = 1'b1;
              ctl_o.rd_sel = RD_POS;
              state_d      = ST_RDWAIT;
            end else begin
              ctl_o.res_load = 1'b1;
              state_d        = ST_DONE;
            end
          end
          default: begin
            if (sts_i.empty) begin
              ctl_o.res_load = 1'b1;
              state_d        = ST_DONE;
            end else begin
              ctl_o.rd_en  = 1'b1;
              ctl_o.rd_sel = RD_ZERO;
              ctl_o.idx_op = IDX_CLR;
              state_d      = ST_SCAN;
            end
          end
        endcase
      end
      ST_SCAN: begin
        if (sts_i.match) begin
          if (sts_i.cmd == CMD_REMOVE && sts_i.next_ok) begin
            ctl_o.rd_en  = 1'b1;
            ctl_o.rd_sel = RD_NEXT;
            state_d      = ST_SHIFT;
          end else begin
            ctl_o.cnt_dec   = (sts_i.cmd == CMD_REMOVE);
            ctl_o.res_load  = 1'b1;
            ctl_o.res_found = 1'b1;
            state_d         = ST_DONE;
          end
        end else if (sts_i.next_ok) begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = RD_NEXT;
          ctl_o.idx_op = IDX_INC;
        end else begin
          ctl_o.res_load = 1'b1;
          state_d        = ST_DONE;
        end
      end
      ST_SHIFT: begin
        ctl_o.shift_wr = 1'b1;
        ctl_o.idx_op   = IDX_INC;
        if (sts_i.next2_ok) begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = RD_NEXT2;
        end else begin
          ctl_o.cnt_dec   = 1'b1;
          ctl_o.res_load  = 1'b1;
          ctl_o.res_found = 1'b1;
          state_d         = ST_DONE;
        end
      end
      ST_RDWAIT: begin
        ctl_o.res_load   = 1'b1;
        ctl_o.res_found  = 1'b1;
        ctl_o.res_use_rd = 1'b1;
        state_d          = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/ovl_dp.sv -----
// Datapath: list memory, entry count, scan index, result and output registers.
// Depends on ovl_pkg, ovl_out_if and the assertion macros; commanded by ovl_ctrl.
`include "ordered_value_list_macros.svh"

module ovl_dp import ovl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic [POS_W-1:0]   position_i,
  input  ctl_t               ctl_i,
  output sts_t               sts_o,
  ovl_out_if.source          out_o
);

  logic [VALUE_W-1:0] mem [CAPACITY];

  cmd_e               cmd_q;
  logic [VALUE_W-1:0] val_q;
  logic [POS_W-1:0]   pos_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [VALUE_W-1:0] rd_data_q;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic               res_found_q, res_drop_q;
  logic [VALUE_W-1:0] res_rv_q;
  logic               out_valid_q;
  logic               out_free;

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q <= cmd_e'(command_i);
      val_q <= value_i;
      pos_q <= position_i;
    end
  end

  always_comb begin
    case (ctl_i.rd_sel)
      RD_POS:   rd_addr = IDX_W'(pos_q);
      RD_NEXT:  rd_addr = idx_q + IDX_W'(1);
      RD_NEXT2: rd_addr = idx_q + IDX_W'(2);
      default:  rd_addr = '0;
    endcase
  end

  assign wr_en   = ctl_i.do_append | ctl_i.shift_wr;
  assign wr_addr = ctl_i.shift_wr ? idx_q : IDX_W'(count_q);
  assign wr_data = ctl_i.shift_wr ? rd_data_q : val_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctl_i.do_append) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctl_i.cnt_dec) begin
      count_d = count_q - CNT_W'(1);
    end
    case (ctl_i.idx_op)
      IDX_CLR: idx_d = '0;
      IDX_INC: idx_d = idx_q + IDX_W'(1);
      default: idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_load) begin
      res_found_q <= ctl_i.res_found;
      res_drop_q  <= ctl_i.res_drop;
      res_rv_q    <= ctl_i.res_use_rd ? rd_data_q : '0;
    end
  end

  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_o.found      <= res_found_q;
      out_o.read_value <= res_rv_q;
      out_o.count      <= COUNT_W'(count_q);
      out_o.full_drop  <= res_drop_q;
    end
  end

  assign out_o.valid = out_valid_q;

  assign sts_o.cmd      = cmd_q;
  assign sts_o.full     = (count_q == CNT_W'(CAPACITY));
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.pos_ok   = (CMP_W'(pos_q) < CMP_W'(count_q));
  assign sts_o.match    = (rd_data_q == val_q);
  assign sts_o.next_ok  = ((CNT_W'(idx_q) + CNT_W'(1)) < count_q);
  assign sts_o.next2_ok = ((CNT_W'(idx_q) + CNT_W'(2)) < count_q);
  assign sts_o.out_free = out_free;

  `OVL_ASSERT_IMP(a_count_cap, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(CAPACITY), "count above capacity")
  `OVL_ASSERT_IMP(a_dec_nonempty, clk_i, rst_ni, ctl_i.cnt_dec, count_q != '0, "removal from empty list")
  `OVL_ASSERT_IMP(a_load_free, clk_i, rst_ni, ctl_i.out_load, out_free, "output register overwritten")
  `OVL_ASSERT_NXT(a_count_hold, clk_i, rst_ni, !ctl_i.do_append && !ctl_i.cnt_dec, $stable(count_q), "count changed without command")

endmodule

// ----- tb/ordered_value_list_tb.sv -----
// Testbench for ordered_value_list: a directed run, then random append/remove/contains/read
// traffic under varying source idle and sink stall, checked against an in-bench list model.
// Depends on ovl_pkg, ovl_in_if/ovl_out_if and the ordered_value_list RTL.
module ordered_value_list_tb;
  import ovl_pkg::*;

  localparam int ITEMS_PER_PHASE = 250;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 2 * CAPACITY + 16;
  localparam logic [3:0][7:0] SRC_IDLE  = {8'd34, 8'd0, 8'd75, 8'd0};
  localparam logic [3:0][7:0] SNK_STALL = {8'd34, 8'd75, 8'd0, 8'd0};

  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0] count;
    logic               full_drop;
  } list_result_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_ANY} mix_e;

  class list_scoreboard;
    logic [VALUE_W-1:0] slots [CAPACITY];
    int unsigned        fill_level;
    list_result_t       pending_q [$];
    int unsigned        mismatches;

    function void note_command(cmd_e op, logic [VALUE_W-1:0] operand, logic [POS_W-1:0] pos);
      list_result_t r;
      int unsigned  hit;
      r   = '0;
      hit = fill_level;
      for (int k = fill_level - 1; k >= 0; k--)
        if (slots[k] == operand) hit = k;
      case (op)
        CMD_APPEND: begin
          if (fill_level < CAPACITY) begin
            slots[fill_level] = operand;
            fill_level++;
            r.found = 1'b1;
          end else begin
            r.full_drop = 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (hit < fill_level) begin
            for (int k = hit; k + 1 < fill_level; k++) slots[k] = slots[k + 1];
            fill_level--;
            r.found = 1'b1;
          end
        end
        CMD_CONTAINS: r.found = (hit < fill_level);
        default: begin
          if (pos < fill_level) begin
            r.found      = 1'b1;
            r.read_value = slots[pos];
          end
        end
      endcase
      r.count = COUNT_W'(fill_level);
      pending_q.push_back(r);
    endfunction

    function void report(string field, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
    endfunction

    function void check_result(logic found, logic [VALUE_W-1:0] rd, logic [COUNT_W-1:0] cnt,
                               logic drop);
      list_result_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat: found=%0b read_value=%0h count=%0d full_drop=%0b",
                 $time, found, rd, cnt, drop);
        return;
      end
      e = pending_q.pop_front();
      if (e.found !== found) report("found", e.found, found);
      if (e.read_value !== rd) report("read_value", e.read_value, rd);
      if (e.count !== cnt) report("count", e.count, cnt);
      if (e.full_drop !== drop) report("full_drop", e.full_drop, drop);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ovl_in_if  in_if ();
  ovl_out_if out_if ();

  ordered_value_list dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  list_scoreboard     sb;
  int unsigned        src_idle_pct;
  int unsigned        snk_stall_pct;
  int unsigned        hold_requests;
  int unsigned        quiet_cycles;
  logic [VALUE_W-1:0] value_pool [8];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sink side: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result(out_if.found, out_if.read_value, out_if.count, out_if.full_drop);
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_cmd(cmd_e op, logic [VALUE_W-1:0] operand, logic [POS_W-1:0] pos);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.command  <= op;
    in_if.value    <= operand;
    in_if.position <= pos;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_command(op, operand, pos);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (sb.fill_level > 0 && r < 40) return sb.slots[$urandom_range(sb.fill_level - 1)];
    if (r < 70) return value_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  task automatic send_random(mix_e mode);
    int unsigned        r;
    cmd_e               op;
    logic [POS_W-1:0]   pos;
    r = $urandom_range(99);
    case (mode)
      MIX_FILL:  op = (r < 70) ? CMD_APPEND : (r < 80) ? CMD_REMOVE :
                      (r < 90) ? CMD_CONTAINS : CMD_READ;
      MIX_DRAIN: op = (r < 60) ? CMD_REMOVE : (r < 70) ? CMD_APPEND :
                      (r < 85) ? CMD_CONTAINS : CMD_READ;
      default:   op = (r < 25) ? CMD_APPEND : (r < 50) ? CMD_REMOVE :
                      (r < 75) ? CMD_CONTAINS : CMD_READ;
    endcase
    r = $urandom_range(99);
    if (op != CMD_READ || sb.fill_level == 0 || r < 30) pos = POS_W'($urandom);
    else if (r < 40) pos = POS_W'(sb.fill_level - 1);
    else pos = POS_W'($urandom_range(sb.fill_level - 1));
    send_cmd(op, pick_value(), pos);
  endtask

  initial begin
    int unsigned sent;
    int unsigned seg;
    mix_e        mode;
    sb = new();
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.command  = CMD_APPEND;
    in_if.value    = '0;
    in_if.position = '0;
    src_idle_pct   = 0;
    snk_stall_pct  = 0;
    hold_requests  = 0;
    quiet_cycles   = 0;
    value_pool[0]  = 32'h8000_0000;
    value_pool[1]  = 32'h7fff_ffff;
    value_pool[2]  = 32'h0000_0000;
    value_pool[3]  = 32'hffff_ffff;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty list corner cases
    send_cmd(CMD_READ, 32'h0, 6'd0);
    send_cmd(CMD_REMOVE, 32'h5, 6'd0);
    send_cmd(CMD_CONTAINS, 32'h0, 6'd0);
    // Extremes, with a duplicate
    send_cmd(CMD_APPEND, 32'h8000_0000, 6'd63);
    send_cmd(CMD_APPEND, 32'h7fff_ffff, 6'd0);
    send_cmd(CMD_APPEND, 32'h0000_0000, 6'd0);
    send_cmd(CMD_APPEND, 32'hffff_ffff, 6'd0);
    send_cmd(CMD_APPEND, 32'h7fff_ffff, 6'd0);
    send_cmd(CMD_CONTAINS, 32'h8000_0000, 6'd0);
    send_cmd(CMD_CONTAINS, 32'h0000_0001, 6'd0);
    send_cmd(CMD_READ, 32'hffff_ffff, 6'd0);
    send_cmd(CMD_READ, 32'h0, 6'd3);
    send_cmd(CMD_READ, 32'h0, 6'd5);
    send_cmd(CMD_READ, 32'h0, 6'd63);
    // Remove takes the first duplicate only
    send_cmd(CMD_REMOVE, 32'h7fff_ffff, 6'd0);
    send_cmd(CMD_READ, 32'h0, 6'd1);
    send_cmd(CMD_READ, 32'h0, 6'd3);
    send_cmd(CMD_REMOVE, 32'd12345, 6'd0);
    send_cmd(CMD_REMOVE, 32'h8000_0000, 6'd0);
    send_cmd(CMD_REMOVE, 32'h7fff_ffff, 6'd0);
    send_cmd(CMD_READ, 32'h0, 6'd0);
    send_cmd(CMD_CONTAINS, 32'h7fff_ffff, 6'd0);

    // Long sink hold-off while the source keeps offering beats
    hold_requests++;
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  = 32'(SRC_IDLE[ph]);
      snk_stall_pct = 32'(SNK_STALL[ph]);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        mode = mix_e'($urandom_range(2));
        seg  = $urandom_range(20, 120);
        for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
        for (int i = 0; i < seg && sent < ITEMS_PER_PHASE; i++) begin
          send_random(mode);
          sent++;
        end
      end
    end
    @(negedge clk_i);
    in_if.valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/ovl_pkg.sv
sv/ovl_intf.sv
sv/ovl_ctrl.sv
sv/ovl_dp.sv
sv/ordered_value_list.sv
tb/ordered_value_list_tb.sv
